@@ rtl/core/qmv_pkg.sv @@
// Shared types and constants for the quorum majority voter.
`default_nettype none
package qmv_pkg;

  localparam int REPORT_W = 16;
  localparam int TALLY_W  = 5;
  localparam int CFG_W    = 5;

  localparam logic [TALLY_W-1:0] TALLY_MAX     = 5'd31;
  localparam logic [CFG_W-1:0]   VOTERS_RESET  = 5'd6;

  // Per-cell lookup status, handed from each cell to the combining logic.
  typedef struct packed {
    logic               hit;
    logic [TALLY_W-1:0] tally;
  } cell_status_t;

  // One result word as held in the output stage.
  typedef struct packed {
    logic                agreed;
    logic [REPORT_W-1:0] decided_value;
  } out_word_t;

endpackage
`default_nettype wire

@@ rtl/core/qmv_cell.sv @@
// One table cell: holds a distinct value and its tally.
`default_nettype none
module qmv_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] val,
  input  logic                  prev_valid,
  input  logic                  any_match,
  input  logic                  upd_en,
  input  logic                  clr,
  output logic                  valid,
  output logic                  match,
  output qmv_pkg::cell_status_t status
);
  import qmv_pkg::*;

  logic [VALUE_BITS-1:0] value_r;
  logic [TALLY_W-1:0]    tally_r, tally_nxt;
  logic [TALLY_W-1:0]    bump;
  logic                  alloc;

  assign valid = (tally_r != '0);
  assign match = valid && (value_r == val);
  // first free cell: the neighbor below is filled, this one is not, and no
  // filled cell already holds the value
  assign alloc = !valid && prev_valid && !any_match;
  assign bump  = (tally_r == TALLY_MAX) ? tally_r : tally_r + TALLY_W'(1);

  assign status.hit   = match || alloc;
  assign status.tally = match ? bump : TALLY_W'(1);

  always_comb begin
    tally_nxt = tally_r;
    if (clr) begin
      tally_nxt = '0;
    end else if (upd_en && status.hit) begin
      tally_nxt = status.tally;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else begin
      tally_r <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && alloc) begin
      value_r <= val;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/qmv_skid.sv @@
// Two-entry output stage: result register plus skid register.
`default_nettype none
module qmv_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qmv_pkg::out_word_t push_word,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output qmv_pkg::out_word_t out_word
);
  import qmv_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t main_word_r, main_word_nxt;
  out_word_t skid_word_r, skid_word_nxt;
  logic      pop;

  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_word  = main_word_r;
  assign pop       = main_valid_r && out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    main_word_nxt  = main_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (skid_valid_r) begin
      // advance the parked word once the head drains
      if (pop) begin
        main_valid_nxt = 1'b1;
        main_word_nxt  = skid_word_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_valid_nxt = push;
      main_word_nxt  = push_word;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_word_r <= main_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/quorum_majority_voter.sv @@
// Quorum majority voter: row of value/tally cells with a two-entry result stage.
// Throughput: one report per cycle while in_tready is high; the cells compare in parallel.
// A result word is registered in the result stage before it is presented on out_*.
// The result stage holds two words: one more result is absorbed while out_* stalls,
// then in_tready drops until the head drains. Reset (rst_n low, synchronous) empties
// the table, clears the decided flag and the result stage, and loads voter_count with 6.
`default_nettype none
module quorum_majority_voter #(
  parameter int MAX_VOTERS = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [qmv_pkg::REPORT_W-1:0]  in_tdata,   // [15:0] report_value
  input  logic                          in_tlast,   // last_report
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [qmv_pkg::REPORT_W-1:0]  out_tdata,  // [15:0] decided_value
  output logic                          out_tuser,  // [0] agreed
  // configuration write: voter_count
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qmv_pkg::CFG_W-1:0]     cfg_data
);
  import qmv_pkg::*;

  logic [CFG_W-1:0]      voter_r;
  logic                  decided_r, decided_nxt;
  logic [VALUE_BITS-1:0] val;
  logic                  in_accept, upd_en, clr;
  logic [MAX_VOTERS:0]   chain;
  logic [MAX_VOTERS-1:0] cell_valid;
  logic [MAX_VOTERS-1:0] hit_vec;
  logic [MAX_VOTERS-1:0] match_vec;
  logic                  any_match;
  cell_status_t          status [MAX_VOTERS];
  logic [TALLY_W-1:0]    tally;
  logic [TALLY_W-1:0]    quorum;
  logic                  any_hit, decide, emit;
  out_word_t             res_word, head_word;

  // Configuration is always taken; the user writes it only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voter_r <= VOTERS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      voter_r <= cfg_data;
    end
  end

  assign in_accept = in_tvalid && in_tready;
  // Reports after agreement are dropped; a marked last report still clears.
  assign upd_en    = in_accept && !decided_r;
  assign clr       = in_accept && in_tlast;
  assign val       = VALUE_BITS'(in_tdata);

  // Cell 0 is always allowed to allocate; each filled cell hands the
  // allocation right up to its neighbor, so the filled cells stay contiguous.
  assign chain[0] = 1'b1;

  for (genvar g = 0; g < MAX_VOTERS; g++) begin : g_cell
    qmv_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .val       (val),
      .prev_valid(chain[g]),
      .any_match (any_match),
      .upd_en    (upd_en),
      .clr       (clr),
      .valid     (chain[g+1]),
      .match     (match_vec[g]),
      .status    (status[g])
    );
    assign hit_vec[g] = status[g].hit;
  end

  // A value already in the table blocks allocation of a second copy.
  assign any_match  = |match_vec;
  assign cell_valid = chain[MAX_VOTERS:1];

  // Values in the table are distinct, so at most one cell hits: OR the tallies.
  always_comb begin
    tally = '0;
    for (int i = 0; i < MAX_VOTERS; i++) begin
      if (status[i].hit) begin
        tally = tally | status[i].tally;
      end
    end
  end

  assign any_hit = |hit_vec;
  assign quorum  = {1'b0, voter_r[CFG_W-1:1]} + TALLY_W'(1);
  assign decide  = upd_en && any_hit && (tally >= quorum);
  // Emit on agreement, or a failure word when the column ends undecided.
  assign emit    = decide || (upd_en && in_tlast);

  assign res_word.agreed        = decide;
  assign res_word.decided_value = decide ? REPORT_W'(val) : '0;

  // Hold the decided flag until the column's last report.
  assign decided_nxt = clr ? 1'b0 : (decided_r || decide);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decided_r <= 1'b0;
    end else begin
      decided_r <= decided_nxt;
    end
  end

  qmv_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept && emit),
    .push_word(res_word),
    .can_push (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_word (head_word)
  );

  assign out_tdata = head_word.decided_value;
  assign out_tuser = head_word.agreed;

`ifndef SYNTHESIS
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cell matched the report");

  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + MAX_VOTERS'(1))) == '0)
    else $error("filled cells are not contiguous from cell 0");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |=> (cell_valid == '0) && !decided_r)
    else $error("table not cleared after last report");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failure word carries a nonzero value");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_quorum_majority_voter.sv @@
// Self-checking testbench for the quorum majority voter, with its decision predictor.
module tb_quorum_majority_voter;
  timeunit 1ns;
  timeprecision 1ps;

  import qmv_pkg::*;

  localparam int TABLE_DEPTH   = 16;   // distinct values the voter keeps per column
  localparam int PHASE_WORDS   = 190;  // report words per random phase
  localparam int HOLD_CYCLES   = 60;   // length of the long output hold-off
  localparam int SETTLE_CYCLES = 6;    // settling time after the owed decisions drain, with margin

  // Tracks the voter's column state and the decision words still owed by the block.
  class decision_board;
    logic [REPORT_W-1:0] cell_value [TABLE_DEPTH];
    logic [TALLY_W-1:0]  cell_tally [TABLE_DEPTH];
    int unsigned         cells_used;
    bit                  column_done;
    logic [CFG_W-1:0]    voters;
    out_word_t           pending_decisions [$];
    int                  errors;
    int                  checked;
    int                  agreements;
    int                  failures;

    function new();
      voters = VOTERS_RESET;
      clear_column();
    endfunction

    function void clear_column();
      foreach (cell_value[i]) begin
        cell_value[i] = '0;
        cell_tally[i] = '0;
      end
      cells_used  = 0;
      column_done = 1'b0;
    endfunction

    // Fold one accepted report into the column and queue the decision it causes, if any.
    function void note_report(logic [REPORT_W-1:0] value, bit last);
      logic [TALLY_W-1:0] quorum;
      logic [TALLY_W-1:0] tally;
      bit                 found;
      out_word_t          word;
      quorum = (voters >> 1) + 5'd1;
      tally  = '0;
      found  = 1'b0;
      if (!column_done) begin
        for (int i = 0; i < cells_used; i++) begin
          if (!found && cell_value[i] == value) begin
            if (cell_tally[i] < TALLY_MAX) cell_tally[i] = cell_tally[i] + 5'd1;
            tally = cell_tally[i];
            found = 1'b1;
          end
        end
        // a new value with the table full is simply not counted
        if (!found && cells_used < TABLE_DEPTH) begin
          cell_value[cells_used] = value;
          cell_tally[cells_used] = 5'd1;
          cells_used++;
          tally = 5'd1;
        end
        if (tally != 0 && tally >= quorum) begin
          column_done        = 1'b1;
          word.agreed        = 1'b1;
          word.decided_value = value;
          pending_decisions  = {pending_decisions, word};
          agreements++;
        end else if (last) begin
          word = '0;
          pending_decisions = {pending_decisions, word};
          failures++;
        end
      end
      if (last) clear_column();
    endfunction

    // Compare one accepted result word with the oldest owed decision.
    function void check_result(logic [REPORT_W-1:0] value, logic agreed);
      out_word_t want;
      checked++;
      if (pending_decisions.size() == 0) begin
        $error("unexpected result word: decided_value %h agreed %b", value, agreed);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (want.decided_value !== value) begin
          $error("decided_value: expected %h, actual %h", want.decided_value, value);
          errors++;
        end
        if (want.agreed !== agreed) begin
          $error("agreed: expected %b, actual %b", want.agreed, agreed);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [REPORT_W-1:0] in_tdata;   // [15:0] report_value
  logic                in_tlast;   // last_report
  logic                out_tvalid;
  logic                out_tready;
  logic [REPORT_W-1:0] out_tdata;  // [15:0] decided_value
  logic                out_tuser;  // [0] agreed
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;

  decision_board board = new();

  int send_idle_pct;   // chance after a report, and per cycle while paused, that the report side pauses
  int recv_idle_pct;   // chance per cycle that the result side stalls
  bit hold_req;        // ask the result side for one long hold-off
  int hold_left;
  int words_sent;
  int settings_done;

  always #2 clk = ~clk;

  quorum_majority_voter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Result side: check every word taken at this edge, then pick ready for the next one.
  // A requested hold-off keeps ready low for the long hold-off while reports keep
  // coming, so the two-word result stage fills and the block must stall its input.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_left = HOLD_CYCLES - 1;
      hold_req   <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Mostly random values, with the all-zeros and all-ones extremes now and then.
  function automatic logic [REPORT_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return REPORT_W'($urandom);
    endcase
  endfunction

  // Offer one report word and hold it until taken; then maybe pause the report side.
  // Within this task the pause is the only place valid drops, so valid is never lowered
  // and raised again in the same time step.
  task automatic send_report(logic [REPORT_W-1:0] value, bit last);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    board.note_report(value, last);
    words_sent++;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Quiesce the report side, drain all owed decisions, let the pipe settle, then
  // write a new voter count.
  task automatic write_voters(logic [CFG_W-1:0] count);
    in_tvalid <= 1'b0;
    while (board.pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.voters = count;
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // One column of reports. Most columns are well formed with a marked last report:
  // a clear favorite, an even split among a few values, or more distinct values than
  // the table holds. The rest are short bursts of noise with random last marks.
  task automatic send_column();
    int                  kind;
    int                  len;
    int                  vc;
    bit                  last;
    logic [REPORT_W-1:0] favorite;
    logic [REPORT_W-1:0] rival_a;
    logic [REPORT_W-1:0] rival_b;
    logic [REPORT_W-1:0] stride;
    logic [REPORT_W-1:0] value;
    vc       = (board.voters == 0) ? 1 : int'(board.voters);
    kind     = $urandom_range(99);
    favorite = pick_value();
    rival_a  = pick_value();
    rival_b  = pick_value();
    stride   = REPORT_W'($urandom) | 16'h0001;
    if (kind < 75)      len = $urandom_range(vc + 3, 1);
    else if (kind < 87) len = $urandom_range(22, 17);
    else                len = $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      if (kind < 55) begin
        value = ($urandom_range(99) < 60) ? favorite :
                ($urandom_range(1) ? rival_a : rival_b);
      end else if (kind < 75) begin
        case ($urandom_range(2))
          0:       value = favorite;
          1:       value = rival_a;
          default: value = rival_b;
        endcase
      end else if (kind < 87) begin
        // sixteen distinct values fill the table; past that, alternate between a
        // value that finds no free cell and the first value of the column
        if (i < TABLE_DEPTH)  value = favorite + REPORT_W'(i) * stride;
        else if (i % 2 != 0)  value = favorite + REPORT_W'(TABLE_DEPTH) * stride;
        else                  value = favorite;
      end else begin
        value = REPORT_W'($urandom);
        last  = ($urandom_range(3) == 0);
      end
      send_report(value, last);
    end
  endtask

  // One random phase: set the idle mix, write the count, optionally request the hold-off, then stream columns.
  task automatic run_phase(logic [CFG_W-1:0] count, int send_pct, int recv_pct, bit squeeze);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    write_voters(count);
    if (squeeze) hold_req <= 1'b1;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) send_column();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    out_tready    = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    words_sent    = 0;
    settings_done = 0;
    send_idle_pct = 33;
    recv_idle_pct = 64;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset count of six, quorum four: agreement mid column, rest of column ignored.
    send_report(16'hFFFF, 1'b0);
    send_report(16'hFFFF, 1'b0);
    send_report(16'hFFFF, 1'b0);
    send_report(16'hFFFF, 1'b0);
    send_report(16'h0000, 1'b1);
    // No value reaches quorum before the mark: failure word.
    send_report(16'h0000, 1'b0);
    send_report(16'h8000, 1'b0);
    send_report(16'h0000, 1'b0);
    send_report(16'h8000, 1'b0);
    send_report(16'h7FFF, 1'b1);
    // Quorum reached exactly on the marked report: one agreed word only.
    send_report(16'h1234, 1'b0);
    send_report(16'h1234, 1'b0);
    send_report(16'h1234, 1'b0);
    send_report(16'hABCD, 1'b0);
    send_report(16'h1234, 1'b1);
    // Counts of zero and one: the first report of a column agrees at once.
    write_voters(5'd0);
    send_report(16'hA5A5, 1'b0);
    send_report(16'h5A5A, 1'b1);
    write_voters(5'd1);
    send_report(16'h5A5A, 1'b1);

    // Report side pauses a third of the time, result side stalls most of the time.
    run_phase(5'd16, 33, 64, 1'b0);
    run_phase(5'd0,  33, 64, 1'b0);
    run_phase(5'd31, 33, 64, 1'b0);
    // Swap the idle mix.
    run_phase(5'd3,  64, 33, 1'b0);
    run_phase(5'd17, 64, 33, 1'b0);
    run_phase(5'd2,  64, 33, 1'b0);
    // No idling; the first report of every count-one column agrees, so the hold-off
    // backs results up into the input.
    run_phase(5'd1,  0, 0, 1'b1);
    run_phase(5'd8,  0, 0, 1'b0);
    run_phase(5'd5,  0, 0, 1'b0);

    in_tvalid <= 1'b0;
    while (board.pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d report words over %0d voter-count writes (0 through 31),",
             words_sent, settings_done);
    $display("  %0d words checked (%0d agreed, %0d failed), %0d-cycle output hold-off.",
             board.checked, board.agreements, board.failures, HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("PASS quorum_majority_voter");
    end else begin
      $display("FAIL quorum_majority_voter");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule.
  initial begin
    #2_000_000;
    $display("FAIL quorum_majority_voter");
    $finish;
  end

endmodule
